FILE: design/arb_pkg.sv
// Shared types, register codes, the product helper and saturation helpers for the affine bounding box block.
`timescale 1ns / 1ps

package arb_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int PIX_MAX  = 8388607;
    localparam int PIX_MIN  = -8388608;
    localparam int DIM_MAX  = 8388607;

    typedef logic signed [23:0] pix_t;
    typedef logic        [22:0] dim_t;
    typedef logic signed [24:0] coord_t;
    typedef logic signed [48:0] prod_t;
    typedef logic signed [32:0] term_t;
    typedef logic signed [34:0] sum_t;
    typedef logic signed [35:0] span_t;
    typedef logic        [2:0]  reg_idx_t;

    localparam reg_idx_t REG_COEF_XX  = 3'd0;
    localparam reg_idx_t REG_COEF_XY  = 3'd1;
    localparam reg_idx_t REG_OFFSET_X = 3'd2;
    localparam reg_idx_t REG_COEF_YX  = 3'd3;
    localparam reg_idx_t REG_COEF_YY  = 3'd4;
    localparam reg_idx_t REG_OFFSET_Y = 3'd5;

    typedef struct packed {
        pix_t coef_xx;
        pix_t coef_xy;
        pix_t offset_x;
        pix_t coef_yx;
        pix_t coef_yy;
        pix_t offset_y;
    } cfg_t;

    // Truncated products: xa/ya scale the x coordinate, xb/yb scale the y coordinate.
    typedef struct packed {
        logic  kind;
        term_t xa0;
        term_t xa1;
        term_t xb0;
        term_t xb1;
        term_t ya0;
        term_t ya1;
        term_t yb0;
        term_t yb1;
    } term_set_t;

    // Product of a Q8.16 coefficient and a Q16.8 coordinate, floored back to Q16.8.
    function automatic term_t mul_floor(pix_t coef, coord_t coord);
        prod_t p;
        p = coef * coord;
        return p[48:16];
    endfunction

    function automatic pix_t sat_s24(sum_t v);
        pix_t r;
        if (v > sum_t'(PIX_MAX))
            r = pix_t'(PIX_MAX);
        else if (v < sum_t'(PIX_MIN))
            r = pix_t'(PIX_MIN);
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic dim_t sat_u23(span_t v);
        dim_t r;
        if (v > span_t'(DIM_MAX))
            r = dim_t'(DIM_MAX);
        else if (v < span_t'(0))
            r = '0;
        else
            r = v[22:0];
        return r;
    endfunction

endpackage

FILE: design/arb_in_if.sv
// Geometry input channel: valid/ready handshake with point or rectangle payload.
`timescale 1ns / 1ps

interface arb_in_if;
    import arb_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    pix_t pos_x;
    pix_t pos_y;
    pix_t extent_w;
    pix_t extent_h;

    modport source (output valid, kind, pos_x, pos_y, extent_w, extent_h, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, extent_w, extent_h, output ready);
endinterface

FILE: design/arb_out_if.sv
// Bounding box output channel: valid/ready handshake with origin and size payload.
`timescale 1ns / 1ps

interface arb_out_if;
    import arb_pkg::*;

    logic valid;
    logic ready;
    pix_t out_x;
    pix_t out_y;
    dim_t out_w;
    dim_t out_h;

    modport source (output valid, out_x, out_y, out_w, out_h, input ready);
    modport sink   (input valid, out_x, out_y, out_w, out_h, output ready);
endinterface

FILE: design/arb_cfg.sv
// APB register file holding the affine matrix coefficients and offsets.
`timescale 1ns / 1ps

module arb_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arb_pkg::ADDR_W-1:0] paddr,
    input  logic [arb_pkg::DATA_W-1:0] pwdata,
    output logic [arb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output arb_pkg::cfg_t              cfg
);
    import arb_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    pix_t     wdata;
    logic     wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wdata  = pwdata[23:0];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COEF_XX:  cfg_next.coef_xx  = wdata;
                REG_COEF_XY:  cfg_next.coef_xy  = wdata;
                REG_OFFSET_X: cfg_next.offset_x = wdata;
                REG_COEF_YX:  cfg_next.coef_yx  = wdata;
                REG_COEF_YY:  cfg_next.coef_yy  = wdata;
                REG_OFFSET_Y: cfg_next.offset_y = wdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COEF_XX:  prdata = DATA_W'(cfg_reg.coef_xx);
            REG_COEF_XY:  prdata = DATA_W'(cfg_reg.coef_xy);
            REG_OFFSET_X: prdata = DATA_W'(cfg_reg.offset_x);
            REG_COEF_YX:  prdata = DATA_W'(cfg_reg.coef_yx);
            REG_COEF_YY:  prdata = DATA_W'(cfg_reg.coef_yy);
            REG_OFFSET_Y: prdata = DATA_W'(cfg_reg.offset_y);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_xx  <= pix_t'(65536);
            cfg_reg.coef_xy  <= '0;
            cfg_reg.offset_x <= '0;
            cfg_reg.coef_yx  <= '0;
            cfg_reg.coef_yy  <= pix_t'(65536);
            cfg_reg.offset_y <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/arb_mult.sv
// Corner formation and product stages: two register stages ending in eight truncated products.
`timescale 1ns / 1ps

module arb_mult (
    input  logic               clk,
    input  logic               rst_n,
    input  arb_pkg::cfg_t      cfg,
    arb_in_if.sink             geom,
    output logic               term_valid,
    input  logic               term_ready,
    output arb_pkg::term_set_t term
);
    import arb_pkg::*;

    typedef struct packed {
        logic   kind;
        coord_t x0;
        coord_t x1;
        coord_t y0;
        coord_t y1;
    } corner_t;

    logic      a_valid_reg;
    logic      a_ready;
    corner_t   a_reg;
    corner_t   a_next;
    logic      b_valid_reg;
    logic      b_ready;
    term_set_t b_reg;
    term_set_t b_next;

    assign b_ready    = !b_valid_reg || term_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign geom.ready = a_ready;
    assign term_valid = b_valid_reg;
    assign term       = b_reg;

    // Corner edges are formed exactly at 25 bits, a negative extent included.
    always_comb
    begin
        a_next.kind = geom.kind;
        a_next.x0   = coord_t'(geom.pos_x);
        a_next.x1   = coord_t'(geom.pos_x) + coord_t'(geom.extent_w);
        a_next.y0   = coord_t'(geom.pos_y);
        a_next.y1   = coord_t'(geom.pos_y) + coord_t'(geom.extent_h);
    end

    // Each term depends on one coordinate only, so the four corners need eight products.
    always_comb
    begin
        b_next.kind = a_reg.kind;
        b_next.xa0  = mul_floor(cfg.coef_xx, a_reg.x0);
        b_next.xa1  = mul_floor(cfg.coef_xx, a_reg.x1);
        b_next.xb0  = mul_floor(cfg.coef_xy, a_reg.y0);
        b_next.xb1  = mul_floor(cfg.coef_xy, a_reg.y1);
        b_next.ya0  = mul_floor(cfg.coef_yx, a_reg.x0);
        b_next.ya1  = mul_floor(cfg.coef_yx, a_reg.x1);
        b_next.yb0  = mul_floor(cfg.coef_yy, a_reg.y0);
        b_next.yb1  = mul_floor(cfg.coef_yy, a_reg.y1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= geom.valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
            a_reg <= a_next;
        if (b_ready)
            b_reg <= b_next;
    end

endmodule

FILE: design/arb_reduce.sv
// Bounding stages: per-term extremes, sums with offsets, then saturation into the output register.
`timescale 1ns / 1ps

module arb_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  arb_pkg::cfg_t      cfg,
    input  logic               term_valid,
    output logic               term_ready,
    input  arb_pkg::term_set_t term,
    arb_out_if.source          bbox
);
    import arb_pkg::*;

    typedef struct packed {
        logic  kind;
        term_t xa_lo;
        term_t xa_hi;
        term_t xb_lo;
        term_t xb_hi;
        term_t ya_lo;
        term_t ya_hi;
        term_t yb_lo;
        term_t yb_hi;
    } bound_t;

    typedef struct packed {
        logic kind;
        sum_t min_x;
        sum_t max_x;
        sum_t min_y;
        sum_t max_y;
    } extent_t;

    logic    c_valid_reg;
    logic    c_ready;
    bound_t  c_reg;
    bound_t  c_next;
    logic    d_valid_reg;
    logic    d_ready;
    extent_t d_reg;
    extent_t d_next;
    logic    e_valid_reg;
    logic    e_ready;
    logic    e_kind_reg;
    pix_t    e_x_reg;
    pix_t    e_y_reg;
    dim_t    e_w_reg;
    dim_t    e_h_reg;
    span_t   span_x;
    span_t   span_y;

    assign e_ready    = !e_valid_reg || bbox.ready;
    assign d_ready    = !d_valid_reg || e_ready;
    assign c_ready    = !c_valid_reg || d_ready;
    assign term_ready = c_ready;

    assign bbox.valid = e_valid_reg;
    assign bbox.out_x = e_x_reg;
    assign bbox.out_y = e_y_reg;
    assign bbox.out_w = e_w_reg;
    assign bbox.out_h = e_h_reg;

    // The corner set pairs each x edge with each y edge, so the extremes of
    // a sum split into the extremes of each term. A point keeps only the first corner.
    always_comb
    begin
        c_next.kind  = term.kind;
        c_next.xa_lo = term.xa0;
        c_next.xa_hi = term.xa0;
        c_next.xb_lo = term.xb0;
        c_next.xb_hi = term.xb0;
        c_next.ya_lo = term.ya0;
        c_next.ya_hi = term.ya0;
        c_next.yb_lo = term.yb0;
        c_next.yb_hi = term.yb0;
        if (term.kind)
        begin
            if (term.xa1 < term.xa0) c_next.xa_lo = term.xa1;
            else                     c_next.xa_hi = term.xa1;
            if (term.xb1 < term.xb0) c_next.xb_lo = term.xb1;
            else                     c_next.xb_hi = term.xb1;
            if (term.ya1 < term.ya0) c_next.ya_lo = term.ya1;
            else                     c_next.ya_hi = term.ya1;
            if (term.yb1 < term.yb0) c_next.yb_lo = term.yb1;
            else                     c_next.yb_hi = term.yb1;
        end
    end

    always_comb
    begin
        d_next.kind  = c_reg.kind;
        d_next.min_x = sum_t'(c_reg.xa_lo) + sum_t'(c_reg.xb_lo) + sum_t'(cfg.offset_x);
        d_next.max_x = sum_t'(c_reg.xa_hi) + sum_t'(c_reg.xb_hi) + sum_t'(cfg.offset_x);
        d_next.min_y = sum_t'(c_reg.ya_lo) + sum_t'(c_reg.yb_lo) + sum_t'(cfg.offset_y);
        d_next.max_y = sum_t'(c_reg.ya_hi) + sum_t'(c_reg.yb_hi) + sum_t'(cfg.offset_y);
    end

    // Width and height come from the unsaturated extremes.
    assign span_x = span_t'(d_reg.max_x) - span_t'(d_reg.min_x);
    assign span_y = span_t'(d_reg.max_y) - span_t'(d_reg.min_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
                c_valid_reg <= term_valid;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
            if (e_ready)
                e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
            c_reg <= c_next;
        if (d_ready)
            d_reg <= d_next;
        if (e_ready)
        begin
            e_kind_reg <= d_reg.kind;
            e_x_reg    <= sat_s24(d_reg.min_x);
            e_y_reg    <= sat_s24(d_reg.min_y);
            e_w_reg    <= d_reg.kind ? sat_u23(span_x) : '0;
            e_h_reg    <= d_reg.kind ? sat_u23(span_y) : '0;
        end
    end

    a_bound_order: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (c_reg.xa_lo <= c_reg.xa_hi) && (c_reg.xb_lo <= c_reg.xb_hi)
                     && (c_reg.ya_lo <= c_reg.ya_hi) && (c_reg.yb_lo <= c_reg.yb_hi))
        else $error("term extremes out of order");

    a_extent_order: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg |-> (d_reg.min_x <= d_reg.max_x) && (d_reg.min_y <= d_reg.max_y))
        else $error("bounding box extremes out of order");

    a_point_size: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !e_kind_reg) |-> (bbox.out_w == '0) && (bbox.out_h == '0))
        else $error("point transaction produced a nonzero size");

endmodule

FILE: design/affine_rect_bounding_box.sv
// Pipeline: five register stages, a and b in arb_mult, then c, d and e in arb_reduce,
// with the result presented on bbox straight from the e stage registers.
// Throughput: one transaction per cycle, set by the valid/ready chain through the stages;
// back-pressure on bbox holds the stages, while empty stages keep accepting.
// Reset: rst_n clears every stage valid bit and loads the identity matrix with zero offsets.
`timescale 1ns / 1ps

module affine_rect_bounding_box (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arb_pkg::ADDR_W-1:0] paddr,
    input  logic [arb_pkg::DATA_W-1:0] pwdata,
    output logic [arb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    arb_in_if.sink                     geom,
    arb_out_if.source                  bbox
);
    import arb_pkg::*;

    cfg_t      cfg;
    logic      term_valid;
    logic      term_ready;
    term_set_t term;

    arb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arb_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .geom       (geom),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term       (term)
    );

    arb_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term       (term),
        .bbox       (bbox)
    );

endmodule
